### design/sdip_pkg.sv
// Package for the saturating decimal integer parser.
// Holds the word types, character codes, register indexes and queue sizes.
// Depends on nothing; every design file imports it.
package sdip_pkg;

   // Character codes and the radix of the number.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam int unsigned RADIX = 10;

   // The byte count saturates here when the budget is unlimited.
   localparam logic [6:0] USED_MAX = 7'h7F;

   // Reset values of the limit registers.
   localparam logic [63:0] MIN_LIMIT_RESET     = 64'h8000_0000_0000_0001;
   localparam logic [63:0] NEG_MIN_LIMIT_RESET = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MAX_LIMIT_RESET     = 64'hFFFF_FFFF_FFFF_FFFF;

   // Small queues between the parts of the block and at its output.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CSR_SIGNED_MODE = 2'd0,
      CSR_MAX_DIGITS  = 2'd1,
      CSR_MIN_LIMIT   = 2'd2,
      CSR_MAX_LIMIT   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STOP_NON_DIGIT   = 2'd0,
      STOP_BUDGET      = 2'd1,
      STOP_END_OF_DATA = 2'd2
   } stop_cause_type;

   typedef struct packed {
      logic       start_req;
      logic       end_of_data;
      logic [7:0] text_byte;
   } req_word_type;

   typedef struct packed {
      logic [63:0] magnitude;
      logic        negative;
      logic [6:0]  bytes_used;
      logic [1:0]  stop_cause;
   } rsp_word_type;

   // A text byte after classification by the front part.
   typedef struct packed {
      logic       start_req;
      logic       end_of_data;
      logic       is_digit;
      logic       is_sign;
      logic       sign_minus;
      logic [3:0] digit;
   } class_word_type;

endpackage

### design/sdip_front.sv
// Front part of the parser: accepts text words, classifies each byte and
// holds the classified words in a short queue for the back part.
// Depends on sdip_pkg.
module sdip_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  sdip_pkg::req_word_type  req_word,
   output logic                    cls_valid,
   output sdip_pkg::class_word_type cls_word,
   input  logic                    cls_pop
);
   import sdip_pkg::*;

   class_word_type             queue_ff [QUEUE_DEPTH];
   class_word_type             class_in;
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                       push_ok;
   logic                       pop_ok;

   always_comb begin
      class_in.start_req   = req_word.start_req;
      class_in.end_of_data = req_word.end_of_data;
      class_in.is_digit    = (req_word.text_byte >= CHAR_ZERO) &&
                             (req_word.text_byte <= CHAR_NINE);
      class_in.is_sign     = (req_word.text_byte == CHAR_PLUS) ||
                             (req_word.text_byte == CHAR_MINUS);
      class_in.sign_minus  = (req_word.text_byte == CHAR_MINUS);
      class_in.digit       = 4'(req_word.text_byte - CHAR_ZERO);
   end

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign cls_valid = (count_ff != '0);
   assign cls_word  = queue_ff[rd_ptr_ff];
   assign push_ok   = push && !full;
   assign pop_ok    = cls_pop && cls_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= class_in;
      end
   end

`ifndef SYNTHESIS
   // The queue never holds more words than it has entries.
   a_front_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("front queue count above depth");

   // An accepted word with nothing taken makes the queue non-empty next cycle.
   a_front_push_visible: assert property (@(posedge clock) disable iff (reset)
      push_ok && !pop_ok |=> cls_valid)
      else $error("pushed word not visible to back part");

   // The pointers meet exactly when the queue is empty or full.
   a_front_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) == ((count_ff == '0) || full))
      else $error("front queue pointers disagree with count");
`endif

endmodule

### design/sdip_back.sv
// Back part of the parser: holds the configuration registers, runs the
// digit accumulator with saturation and queues finished results.
// Depends on sdip_pkg.
module sdip_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  sdip_pkg::csr_index_type  csr_index,
   input  logic [63:0]              csr_data,
   input  logic                     cls_valid,
   input  sdip_pkg::class_word_type cls_word,
   output logic                     cls_pop,
   output logic                     empty,
   input  logic                     pop,
   output sdip_pkg::rsp_word_type   rsp_word
);
   import sdip_pkg::*;

   // Configuration registers. The negated minimum is kept ready for use.
   logic        signed_mode_ff, signed_mode_in;
   logic [6:0]  max_digits_ff, max_digits_in;
   logic [63:0] neg_min_limit_ff, neg_min_limit_in;
   logic [63:0] max_limit_ff, max_limit_in;

   // Parse state.
   logic        active_ff, active_in;
   logic [63:0] acc_ff, acc_in;
   logic [6:0]  used_ff, used_in;
   logic        minus_ff, minus_in;
   logic        first_ff, first_in;

   // Result queue.
   rsp_word_type           res_queue_ff [QUEUE_DEPTH];
   rsp_word_type           res_word;
   logic [QUEUE_PTR_W-1:0] res_wr_ptr_ff, res_wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] res_rd_ptr_ff, res_rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] res_count_ff, res_count_in;
   logic                   res_full;
   logic                   res_push;
   logic                   res_pop_ok;
   stop_cause_type         res_cause;

   logic        fire;
   logic        act_cur;
   logic [63:0] acc_cur;
   logic [6:0]  used_cur;
   logic [6:0]  used_inc;
   logic        minus_cur;
   logic        first_cur;
   logic [67:0] digit_sum;
   logic [63:0] limit;
   logic        saturate;
   logic [63:0] digit_next;

   function automatic logic budget_met(input logic [6:0] used, input logic [6:0] budget);
      return (budget != '0) && (used >= budget);
   endfunction

   always_comb begin
      signed_mode_in   = signed_mode_ff;
      max_digits_in    = max_digits_ff;
      neg_min_limit_in = neg_min_limit_ff;
      max_limit_in     = max_limit_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SIGNED_MODE: signed_mode_in   = csr_data[0];
            CSR_MAX_DIGITS:  max_digits_in    = csr_data[6:0];
            CSR_MIN_LIMIT:   neg_min_limit_in = 64'(0) - csr_data;
            CSR_MAX_LIMIT:   max_limit_in     = csr_data;
            default:         max_limit_in     = max_limit_ff;
         endcase
      end
   end

   assign res_full = (res_count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign fire     = cls_valid && !res_full;
   assign cls_pop  = fire;

   // A start marker restarts the number with this word's byte.
   assign act_cur   = cls_word.start_req || active_ff;
   assign acc_cur   = cls_word.start_req ? '0 : acc_ff;
   assign used_cur  = cls_word.start_req ? '0 : used_ff;
   assign minus_cur = cls_word.start_req ? 1'b0 : minus_ff;
   assign first_cur = cls_word.start_req || first_ff;
   assign used_inc  = (used_cur == USED_MAX) ? used_cur : used_cur + 1'b1;

   // Times ten as two shifts and an add; the top bits flag a true overflow.
   assign digit_sum  = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0}
                     + {64'd0, cls_word.digit};
   assign limit      = minus_cur ? neg_min_limit_ff : max_limit_ff;
   assign saturate   = (digit_sum[67:64] != '0) || (digit_sum[63:0] > limit);
   assign digit_next = saturate ? limit : digit_sum[63:0];

   always_comb begin
      active_in = active_ff;
      acc_in    = acc_ff;
      used_in   = used_ff;
      minus_in  = minus_ff;
      first_in  = first_ff;
      res_push  = 1'b0;
      res_cause = STOP_NON_DIGIT;
      if (fire) begin
         active_in = act_cur;
         acc_in    = acc_cur;
         used_in   = used_cur;
         minus_in  = minus_cur;
         first_in  = first_cur;
         if (act_cur) begin
            if (budget_met(used_cur, max_digits_ff)) begin
               res_push  = 1'b1;
               res_cause = STOP_BUDGET;
            end else if (cls_word.end_of_data) begin
               res_push  = 1'b1;
               res_cause = STOP_END_OF_DATA;
            end else if (first_cur && signed_mode_ff && cls_word.is_sign) begin
               minus_in = cls_word.sign_minus;
               used_in  = used_inc;
               first_in = 1'b0;
            end else if (cls_word.is_digit) begin
               acc_in   = digit_next;
               used_in  = used_inc;
               first_in = 1'b0;
            end else begin
               res_push  = 1'b1;
               res_cause = STOP_NON_DIGIT;
            end
            if (!res_push && budget_met(used_in, max_digits_ff)) begin
               res_push  = 1'b1;
               res_cause = STOP_BUDGET;
            end
         end
         if (res_push) begin
            active_in = 1'b0;
         end
      end
   end

   always_comb begin
      res_word.magnitude  = acc_in;
      res_word.negative   = minus_in;
      res_word.bytes_used = used_in;
      res_word.stop_cause = res_cause;
   end

   assign empty      = (res_count_ff == '0);
   assign rsp_word   = res_queue_ff[res_rd_ptr_ff];
   assign res_pop_ok = pop && !empty;

   always_comb begin
      res_wr_ptr_in = res_wr_ptr_ff;
      res_rd_ptr_in = res_rd_ptr_ff;
      res_count_in  = res_count_ff;
      if (res_push) begin
         res_wr_ptr_in = (res_wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                         '0 : res_wr_ptr_ff + 1'b1;
      end
      if (res_pop_ok) begin
         res_rd_ptr_in = (res_rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                         '0 : res_rd_ptr_ff + 1'b1;
      end
      if (res_push && !res_pop_ok) begin
         res_count_in = res_count_ff + 1'b1;
      end else if (res_pop_ok && !res_push) begin
         res_count_in = res_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff   <= 1'b0;
         max_digits_ff    <= '0;
         neg_min_limit_ff <= NEG_MIN_LIMIT_RESET;
         max_limit_ff     <= MAX_LIMIT_RESET;
         active_ff        <= 1'b0;
         acc_ff           <= '0;
         used_ff          <= '0;
         minus_ff         <= 1'b0;
         first_ff         <= 1'b0;
         res_wr_ptr_ff    <= '0;
         res_rd_ptr_ff    <= '0;
         res_count_ff     <= '0;
      end else begin
         signed_mode_ff   <= signed_mode_in;
         max_digits_ff    <= max_digits_in;
         neg_min_limit_ff <= neg_min_limit_in;
         max_limit_ff     <= max_limit_in;
         active_ff        <= active_in;
         acc_ff           <= acc_in;
         used_ff          <= used_in;
         minus_ff         <= minus_in;
         first_ff         <= first_in;
         res_wr_ptr_ff    <= res_wr_ptr_in;
         res_rd_ptr_ff    <= res_rd_ptr_in;
         res_count_ff     <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_queue_ff[res_wr_ptr_ff] <= res_word;
      end
   end

`ifndef SYNTHESIS
   // Results are only produced by a word taken from the front queue.
   a_back_push_needs_fire: assert property (@(posedge clock) disable iff (reset)
      res_push |-> fire)
      else $error("result produced without a consumed word");

   // Finishing a number always leaves the parser idle.
   a_back_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      res_push |=> !active_ff)
      else $error("parser still active after a result");

   // While the first byte is pending, nothing has been counted yet.
   a_back_first_means_zero: assert property (@(posedge clock) disable iff (reset)
      active_ff && first_ff |-> used_ff == '0)
      else $error("first byte pending with a nonzero count");

   // The result queue never overfills.
   a_back_count_bound: assert property (@(posedge clock) disable iff (reset)
      res_count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue count above depth");
`endif

endmodule

### design/saturating_decimal_integer_parser.sv
// An accepted word passes the front queue and the back part; any result it
// yields shows in the result queue (empty low). Throughput: one word per cycle
// while queues have room, set by the accumulator loop (times ten, add, compare).
// Reset is synchronous and active high: queues empty, parser idle and the
// registers at their defaults (unsigned, no budget, widest limits).
module saturating_decimal_integer_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  sdip_pkg::req_word_type  req_word,
   output logic                    empty,
   input  logic                    pop,
   output sdip_pkg::rsp_word_type  rsp_word,
   input  logic                    csr_write_en,
   input  sdip_pkg::csr_index_type csr_index,
   input  logic [63:0]             csr_data
);
   import sdip_pkg::*;

   // Classified words travel from the front part to the back part through
   // a two-entry queue, so the input side still takes a word in a cycle in
   // which the back part waits on a full result queue; only a longer wait
   // fills the queue and holds off the input.
   logic           cls_valid;
   logic           cls_pop;
   class_word_type cls_word;

   // The front part finds digits and signs in each text byte; it needs no
   // configuration, so sign handling that depends on the mode is left to
   // the back part.
   sdip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .cls_valid (cls_valid),
      .cls_word  (cls_word),
      .cls_pop   (cls_pop)
   );

   // The back part keeps the number in progress and the configuration.
   // It consumes a word whenever its result queue has room, and each word
   // yields at most one result word, so the result queue is the only
   // place where output back-pressure reaches the parser.
   sdip_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cls_valid    (cls_valid),
      .cls_word     (cls_word),
      .cls_pop      (cls_pop),
      .empty        (empty),
      .pop          (pop),
      .rsp_word     (rsp_word)
   );

endmodule
